### src/lwgs_pkg.sv
// shared constants and types for the wave gradient led stepper
`timescale 1ns / 1ps
package lwgs_pkg;

    localparam int PT_SLOTS  = 16;
    localparam int PT_AW     = 4;
    localparam int LED_SLOTS = 64;
    localparam int LED_AW    = 6;
    localparam int SLOPE_W   = 17;
    localparam int DIV_DW    = 31;
    localparam int DIV_VW    = 15;

    localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [1:0] CFG_WAVE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_LED_COUNT   = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic [7:0] level_t;
    typedef logic [2:0][7:0] rgb_t;
    typedef logic signed [SLOPE_W-1:0] slope_t;

    // per-led state word kept in the led memory
    typedef struct packed {
        rgb_t             color;
        logic [PT_AW-1:0] seg;
        logic [7:0]       tick;
    } led_word_t;

endpackage

### src/lwgs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lwgs_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/lwgs_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lwgs_div #(
    parameter int DW = 31,
    parameter int VW = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dsr_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_next;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                cnt_reg  <= CW'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[DW-2:0], ge};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### src/led_wave_gradient_stepper.sv
// top level of the wave gradient led stepper
`timescale 1ns / 1ps
// A load transaction stores one gradient point. The load that stores the last
// point starts a seeding run: every segment slope channel goes through the shared
// divider (3 per point), two more divisions size the waves, and each seeded led
// then takes five divisions; req_ready stays low throughout. A tick transaction
// walks the leds one at a time through the led memory, in eight steps per led
// (read, data capture, three channel steps on the shared adder, advance, jump,
// write), and an output stall holds the walk at the write step. The last result
// of a tick may still sit in the output register while the next transaction is
// taken.
module led_wave_gradient_stepper #(
    parameter int MAX_POINTS = 16,
    parameter int MAX_LEDS   = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                req_type,
    input  lwgs_pkg::level_t    point_red,
    input  lwgs_pkg::level_t    point_green,
    input  lwgs_pkg::level_t    point_blue,
    input  logic [7:0]          point_duration,
    output logic                led_valid,
    input  logic                led_ready,
    output logic [5:0]          led_index,
    output lwgs_pkg::level_t    out_red,
    output lwgs_pkg::level_t    out_green,
    output lwgs_pkg::level_t    out_blue,
    output logic                last_led
);

    import lwgs_pkg::*;

    localparam int P_LIM_I = (MAX_POINTS < PT_SLOTS) ? MAX_POINTS : PT_SLOTS;
    localparam int N_LIM_I = (MAX_LEDS < LED_SLOTS) ? MAX_LEDS : LED_SLOTS;
    localparam logic [4:0] P_LIM = 5'(P_LIM_I);
    localparam logic [6:0] N_LIM = 7'(N_LIM_I);
    localparam int LW = $bits(led_word_t);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SL_A, S_SL_B, S_SL_DIV, S_SL_WAIT,
        S_WV_DIV, S_WV_WAIT, S_PER_DIV, S_PER_WAIT,
        S_LS_SEG, S_LS_SEGW, S_LS_PT, S_LS_TDIV, S_LS_TW,
        S_LS_MUL, S_LS_CDIV, S_LS_CW, S_LS_WR,
        S_TK_RD, S_TK_DAT, S_TK_CH, S_TK_ADV, S_TK_JMP, S_TK_OUT
    } state_t;

    state_t state_reg;

    logic [4:0] pc_reg;
    logic [6:0] ww_reg;
    logic [6:0] lc_reg;

    rgb_t       pt_col_reg [PT_SLOTS];
    logic [7:0] pt_dur_reg [PT_SLOTS];
    slope_t     slope_reg  [PT_SLOTS][3];
    logic [PT_AW-1:0] load_pos_reg;
    logic [LED_SLOTS-1:0] led_vld_reg;

    logic [PT_AW-1:0]  k_reg;
    logic [1:0]        ch_reg;
    rgb_t              from_reg;
    rgb_t              to_reg;
    logic [7:0]        d_reg;
    logic              neg_reg;
    logic [6:0]        waves_reg;
    logic [6:0]        per_reg;
    logic [6:0]        wave_i_reg;
    logic [5:0]        j_reg;
    logic [LED_AW-1:0] idx_reg;
    logic [5:0]        r_reg;
    logic [13:0]       rd_reg;
    logic signed [31:0] prod_reg;
    led_word_t         cur_reg;
    logic              jump_reg;

    logic              div_start_reg;
    logic [DIV_DW-1:0] div_a_reg;
    logic [DIV_VW-1:0] div_b_reg;
    logic              div_busy;
    logic              div_done;
    logic [DIV_DW-1:0] div_q;
    logic [DIV_VW-1:0] div_r;

    logic       led_valid_reg;
    logic [5:0] led_index_reg;
    rgb_t       out_col_reg;
    logic       last_led_reg;

    logic [4:0] p_eff;
    logic [6:0] n_eff;
    logic [6:0] w_eff;
    logic [PT_AW-1:0] k_nx;
    logic [PT_AW-1:0] seg_nx;
    logic [PT_AW-1:0] pt_addr;
    rgb_t       pt_col;
    logic [7:0] pt_dur_eff;
    slope_t     pt_slope;
    logic       out_free;
    logic       ram_we;
    logic       ram_re;
    logic [LW-1:0] ram_rdata;

    logic signed [8:0]  sl_diff;
    logic [7:0]         sl_mag;
    logic [10:0]        jp;
    logic [14:0]        cp;
    logic signed [32:0] num;
    logic [30:0]        num_c;
    logic signed [17:0] tv;
    logic [15:0]        tcl;
    logic [16:0]        rnd;

    assign p_eff = (pc_reg == 5'd0) ? 5'd1 : ((pc_reg > P_LIM) ? P_LIM : pc_reg);
    assign n_eff = (lc_reg == 7'd0) ? 7'd1 : ((lc_reg > N_LIM) ? N_LIM : lc_reg);
    assign w_eff = (ww_reg == 7'd0) ? 7'd1 : ww_reg;

    assign k_nx   = (({1'b0, k_reg} + 5'd1) >= p_eff) ? '0 : k_reg + PT_AW'(1);
    assign seg_nx = (({1'b0, cur_reg.seg} + 5'd1) >= p_eff) ? '0 : cur_reg.seg + PT_AW'(1);

    // one read address into the point store per cycle
    always_comb
    begin
        priority case (state_reg)
            S_SL_A:  pt_addr = k_reg;
            S_SL_B:  pt_addr = k_nx;
            default: pt_addr = cur_reg.seg;
        endcase
    end

    assign pt_col     = pt_col_reg[pt_addr];
    assign pt_dur_eff = (pt_dur_reg[pt_addr] == 8'd0) ? 8'd1 : pt_dur_reg[pt_addr];
    assign pt_slope   = slope_reg[pt_addr][ch_reg];

    assign sl_diff = $signed({1'b0, to_reg[ch_reg]}) - $signed({1'b0, from_reg[ch_reg]});
    assign sl_mag  = sl_diff[8] ? 8'(-sl_diff) : sl_diff[7:0];

    assign jp    = 11'(j_reg) * 11'(p_eff);
    assign cp    = 15'(from_reg[ch_reg]) * 15'(per_reg);
    assign num   = $signed({10'b0, cp, 8'b0}) + 33'(prod_reg);
    assign num_c = num[32] ? '0 : num[30:0];

    assign tv  = $signed({2'b0, cur_reg.color[ch_reg], 8'b0}) + 18'(pt_slope);
    assign tcl = tv[17] ? 16'd0 : ((tv > 18'sd65280) ? 16'd65280 : tv[15:0]);
    assign rnd = 17'(tcl) + 17'd128;

    assign out_free = !led_valid_reg || led_ready;
    assign ram_we   = (state_reg == S_LS_WR) || ((state_reg == S_TK_OUT) && out_free);
    assign ram_re   = (state_reg == S_TK_RD);
    assign req_ready = (state_reg == S_IDLE);

    lwgs_div #(
        .DW(DIV_DW),
        .VW(DIV_VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r)
    );

    lwgs_ram #(
        .WIDTH(LW),
        .DEPTH(LED_SLOTS)
    ) u_led_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(idx_reg),
        .wdata(cur_reg),
        .re   (ram_re),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 5'd4;
            ww_reg        <= 7'd16;
            lc_reg        <= 7'd64;
            for (int i = 0; i < PT_SLOTS; i++)
            begin
                pt_col_reg[i] <= '0;
                pt_dur_reg[i] <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    slope_reg[i][c] <= '0;
                end
            end
            load_pos_reg  <= '0;
            led_vld_reg   <= '0;
            k_reg         <= '0;
            ch_reg        <= '0;
            from_reg      <= '0;
            to_reg        <= '0;
            d_reg         <= '0;
            neg_reg       <= 1'b0;
            waves_reg     <= '0;
            per_reg       <= '0;
            wave_i_reg    <= '0;
            j_reg         <= '0;
            idx_reg       <= '0;
            r_reg         <= '0;
            rd_reg        <= '0;
            prod_reg      <= '0;
            cur_reg       <= '0;
            jump_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            div_a_reg     <= '0;
            div_b_reg     <= '0;
            led_valid_reg <= 1'b0;
            led_index_reg <= '0;
            out_col_reg   <= '0;
            last_led_reg  <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (led_valid_reg && led_ready)
            begin
                led_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POINT_COUNT: pc_reg <= cfg_data[4:0];
                    CFG_WAVE_WIDTH:  ww_reg <= cfg_data;
                    CFG_LED_COUNT:   lc_reg <= cfg_data;
                    default:         ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req_type == REQ_TICK)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_TK_RD;
                        end
                        else if ({1'b0, load_pos_reg} < p_eff)
                        begin
                            pt_col_reg[load_pos_reg] <= {point_blue, point_green, point_red};
                            pt_dur_reg[load_pos_reg] <= point_duration;
                            if (({1'b0, load_pos_reg} + 5'd1) == p_eff)
                            begin
                                load_pos_reg <= '0;
                                k_reg        <= '0;
                                state_reg    <= S_SL_A;
                            end
                            else
                            begin
                                load_pos_reg <= load_pos_reg + PT_AW'(1);
                            end
                        end
                    end
                end

                // segment slopes, one channel per division
                S_SL_A:
                begin
                    from_reg  <= pt_col;
                    d_reg     <= pt_dur_eff;
                    ch_reg    <= '0;
                    state_reg <= S_SL_B;
                end
                S_SL_B:
                begin
                    to_reg    <= pt_col;
                    state_reg <= S_SL_DIV;
                end
                S_SL_DIV:
                begin
                    // round half away from zero: (2*mag*256 + d) / (2*d)
                    div_a_reg     <= DIV_DW'({sl_mag, 9'b0}) + DIV_DW'(d_reg);
                    div_b_reg     <= DIV_VW'({d_reg, 1'b0});
                    neg_reg       <= sl_diff[8];
                    div_start_reg <= 1'b1;
                    state_reg     <= S_SL_WAIT;
                end
                S_SL_WAIT:
                begin
                    if (div_done)
                    begin
                        slope_reg[k_reg][ch_reg] <= neg_reg ? -$signed(div_q[SLOPE_W-1:0])
                                                            : $signed(div_q[SLOPE_W-1:0]);
                        if (ch_reg == 2'd2)
                        begin
                            ch_reg <= '0;
                            if (({1'b0, k_reg} + 5'd1) == p_eff)
                            begin
                                state_reg <= S_WV_DIV;
                            end
                            else
                            begin
                                k_reg     <= k_reg + PT_AW'(1);
                                state_reg <= S_SL_A;
                            end
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= S_SL_DIV;
                        end
                    end
                end

                S_WV_DIV:
                begin
                    div_a_reg     <= DIV_DW'(n_eff);
                    div_b_reg     <= DIV_VW'(w_eff);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_WV_WAIT;
                end
                S_WV_WAIT:
                begin
                    if (div_done)
                    begin
                        waves_reg <= (div_q[6:0] == 7'd0) ? 7'd1 : div_q[6:0];
                        state_reg <= S_PER_DIV;
                    end
                end
                S_PER_DIV:
                begin
                    div_a_reg     <= DIV_DW'(n_eff);
                    div_b_reg     <= DIV_VW'(waves_reg);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_PER_WAIT;
                end
                S_PER_WAIT:
                begin
                    if (div_done)
                    begin
                        per_reg    <= div_q[6:0];
                        idx_reg    <= '0;
                        j_reg      <= '0;
                        wave_i_reg <= '0;
                        state_reg  <= S_LS_SEG;
                    end
                end

                // led seeding
                S_LS_SEG:
                begin
                    div_a_reg     <= DIV_DW'(jp);
                    div_b_reg     <= DIV_VW'(per_reg);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_LS_SEGW;
                end
                S_LS_SEGW:
                begin
                    if (div_done)
                    begin
                        cur_reg.seg <= div_q[PT_AW-1:0];
                        r_reg       <= div_r[5:0];
                        state_reg   <= S_LS_PT;
                    end
                end
                S_LS_PT:
                begin
                    from_reg  <= pt_col;
                    d_reg     <= pt_dur_eff;
                    rd_reg    <= 14'(r_reg) * 14'(pt_dur_eff);
                    state_reg <= S_LS_TDIV;
                end
                S_LS_TDIV:
                begin
                    div_a_reg     <= DIV_DW'(rd_reg);
                    div_b_reg     <= DIV_VW'(per_reg);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_LS_TW;
                end
                S_LS_TW:
                begin
                    if (div_done)
                    begin
                        cur_reg.tick <= div_q[7:0];
                        ch_reg       <= '0;
                        state_reg    <= S_LS_MUL;
                    end
                end
                S_LS_MUL:
                begin
                    prod_reg  <= 32'($signed({1'b0, rd_reg})) * 32'(pt_slope);
                    state_reg <= S_LS_CDIV;
                end
                S_LS_CDIV:
                begin
                    div_a_reg     <= num_c + DIV_DW'({per_reg, 7'b0});
                    div_b_reg     <= DIV_VW'({per_reg, 8'b0});
                    div_start_reg <= 1'b1;
                    state_reg     <= S_LS_CW;
                end
                S_LS_CW:
                begin
                    if (div_done)
                    begin
                        cur_reg.color[ch_reg] <= (div_q > DIV_DW'(255)) ? 8'd255 : div_q[7:0];
                        if (ch_reg == 2'd2)
                        begin
                            state_reg <= S_LS_WR;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= S_LS_MUL;
                        end
                    end
                end
                S_LS_WR:
                begin
                    led_vld_reg[idx_reg] <= 1'b1;
                    idx_reg              <= idx_reg + LED_AW'(1);
                    if (({1'b0, j_reg} + 7'd1) == per_reg)
                    begin
                        j_reg <= '0;
                        if ((wave_i_reg + 7'd1) == waves_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            wave_i_reg <= wave_i_reg + 7'd1;
                            state_reg  <= S_LS_SEG;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 6'd1;
                        state_reg <= S_LS_SEG;
                    end
                end

                // tick walk, one led at a time
                S_TK_RD:
                begin
                    state_reg <= S_TK_DAT;
                end
                S_TK_DAT:
                begin
                    cur_reg   <= led_vld_reg[idx_reg] ? led_word_t'(ram_rdata) : '0;
                    ch_reg    <= '0;
                    state_reg <= S_TK_CH;
                end
                S_TK_CH:
                begin
                    cur_reg.color[ch_reg] <= rnd[15:8];
                    if (ch_reg == 2'd2)
                    begin
                        state_reg <= S_TK_ADV;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 2'd1;
                    end
                end
                S_TK_ADV:
                begin
                    if ((9'(cur_reg.tick) + 9'd1) >= 9'(pt_dur_eff))
                    begin
                        cur_reg.seg  <= seg_nx;
                        cur_reg.tick <= '0;
                        jump_reg     <= 1'b1;
                    end
                    else
                    begin
                        cur_reg.tick <= cur_reg.tick + 8'd1;
                        jump_reg     <= 1'b0;
                    end
                    state_reg <= S_TK_JMP;
                end
                S_TK_JMP:
                begin
                    if (jump_reg)
                    begin
                        cur_reg.color <= pt_col;
                    end
                    state_reg <= S_TK_OUT;
                end
                S_TK_OUT:
                begin
                    if (out_free)
                    begin
                        led_vld_reg[idx_reg] <= 1'b1;
                        led_valid_reg        <= 1'b1;
                        led_index_reg        <= idx_reg;
                        out_col_reg          <= cur_reg.color;
                        if (({1'b0, idx_reg} + 7'd1) == n_eff)
                        begin
                            last_led_reg <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            last_led_reg <= 1'b0;
                            idx_reg      <= idx_reg + LED_AW'(1);
                            state_reg    <= S_TK_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign led_valid = led_valid_reg;
    assign led_index = led_index_reg;
    assign out_red   = out_col_reg[0];
    assign out_green = out_col_reg[1];
    assign out_blue  = out_col_reg[2];
    assign last_led  = last_led_reg;

    // the divider is never restarted while a division is in flight
    assert property (@(posedge clk) disable iff (!rst_n) div_start_reg |-> !div_busy)
        else $error("divider restarted while busy");

    // the last result of a tick belongs to the last driven led
    assert property (@(posedge clk) disable iff (!rst_n)
        (led_valid && last_led) |-> (({1'b0, led_index} + 7'd1) == n_eff))
        else $error("last_led on wrong led");

    // every led memory write leaves that entry marked valid
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> led_vld_reg[$past(idx_reg)])
        else $error("led entry not marked valid after write");

    // a new result is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TK_OUT && led_valid_reg && !led_ready) |=> $stable(led_index_reg))
        else $error("output register overwritten while stalled");

endmodule
